### rtl/bbs_pkg.sv
// shared constants for the byte block sorter
// no dependencies; used by the top level, the ram and the checker
`default_nettype none

package bbs_pkg;

  localparam int MAX_COUNT_DEF = 16;  // default block capacity
  localparam int VALUE_W       = 8;   // width of one stored byte

endpackage

`default_nettype wire

### rtl/byte_block_sorter_top.sv
// byte block sorter top level: load, in-memory bubble sort and ordered output
// depends on bbs_pkg and bbs_ram
`default_nettype none

// Bytes arrive on the in_ stream and are written one per cycle into a block
// ram of MAX_COUNT entries; a request with in_tlast high closes the block.
// Bytes past capacity are dropped and every result of that block then carries
// out_tuser high. After closing, the block is sorted ascending in place by a
// bubble sort that streams through the single-read-port ram: each pass over
// entries 0..hi reads one entry a cycle, keeps the running maximum in a carry
// register and writes the smaller value back one entry behind, with hi
// falling from N-1 down to 1 for a block of N bytes (no pass for N = 1).
// The sorted bytes then leave one at a time (ram read, output load,
// handshake), waiting out any out_tready stall, the largest marked with
// out_tlast. in_tready is high only while the block is loading, so a new
// block is taken once the previous one has been fully delivered. Equal
// bytes are never exchanged, so the sort is stable.

module byte_block_sorter_top #(
  parameter int MAX_COUNT = bbs_pkg::MAX_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] value
  input  wire logic       in_tlast,   // last_item
  // result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] sorted_value
  output logic            out_tlast,  // final_value
  output logic            out_tuser   // [0] overflowed
);

  localparam int VW = bbs_pkg::VALUE_W;
  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;  // ram address
  localparam int CW = AW + 1;                                   // fill count
  localparam int JW = AW + 1;                                   // pass step

  // sequencer states
  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,  // taking bytes into the block
    S_SORT  = 5'b00010,  // bubble passes over the ram
    S_ORD   = 5'b00100,  // read the next sorted entry
    S_OLD   = 5'b01000,  // load the output register
    S_OWAIT = 5'b10000   // wait for the result to be taken
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            ovf_r, ovf_nxt;
  logic [AW-1:0]   hi_r, hi_nxt;       // top entry of the current pass
  logic [JW-1:0]   j_r, j_nxt;         // step within the pass
  logic [VW-1:0]   carry_r, carry_nxt; // running maximum of the pass
  logic [AW-1:0]   k_r, k_nxt;         // output index
  logic            out_valid_r, out_valid_nxt;
  logic [VW-1:0]   out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_user_r, out_user_nxt;

  // ram port
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [VW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [VW-1:0]   ram_rdata;

  logic            in_acc;
  logic            has_room;
  logic [CW-1:0]   count_new;
  logic [JW-1:0]   hi_ext;
  logic [JW-1:0]   j_m2;
  logic            k_is_last;

  bbs_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign has_room  = (fill_r < CW'(MAX_COUNT));
  // block size once the current request has been stored or dropped
  assign count_new = has_room ? (fill_r + 1'b1) : fill_r;
  assign hi_ext    = {1'b0, hi_r};
  assign j_m2      = j_r - JW'(2);
  assign k_is_last = (({1'b0, k_r} + 1'b1) == fill_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    carry_nxt     = carry_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_r[AW-1:0];
    ram_wdata     = in_tdata;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            ram_we = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          fill_nxt = count_new;
          if (in_tlast) begin
            j_nxt = '0;
            k_nxt = '0;
            hi_nxt = AW'(count_new - 1'b1);
            // a single byte needs no sorting
            state_nxt = (count_new == CW'(1)) ? S_ORD : S_SORT;
          end
        end
      end

      S_SORT: begin
        j_nxt = j_r + 1'b1;
        if (j_r == '0) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end else if (j_r == JW'(1)) begin
          carry_nxt = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = AW'(1);
        end else if (j_r <= hi_ext + 1'b1) begin
          // entry j-1 is in; the smaller one goes back one slot behind
          ram_we    = 1'b1;
          ram_waddr = j_m2[AW-1:0];
          if (carry_r > ram_rdata) begin
            ram_wdata = ram_rdata;
          end else begin
            ram_wdata = carry_r;
            carry_nxt = ram_rdata;
          end
          if (j_r <= hi_ext) begin
            ram_re    = 1'b1;
            ram_raddr = j_r[AW-1:0];
          end
        end else begin
          // pass ends: the maximum settles at the top entry
          ram_we    = 1'b1;
          ram_waddr = hi_r;
          ram_wdata = carry_r;
          j_nxt     = '0;
          if (hi_r == AW'(1)) begin
            state_nxt = S_ORD;
          end else begin
            hi_nxt = hi_r - 1'b1;
          end
        end
      end

      S_ORD: begin
        ram_re    = 1'b1;
        ram_raddr = k_r;
        state_nxt = S_OLD;
      end

      S_OLD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = ram_rdata;
        out_last_nxt  = k_is_last;
        out_user_nxt  = ovf_r;
        state_nxt     = S_OWAIT;
      end

      S_OWAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    hi_r       <= hi_nxt;
    j_r        <= j_nxt;
    carry_r    <= carry_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

### rtl/bbs_ram.sv
// generic single-write, single-read ram with a registered read port
// depends on bbs_pkg for its default width and depth
`default_nettype none

module bbs_ram #(
  parameter int WIDTH = bbs_pkg::VALUE_W,
  parameter int DEPTH = bbs_pkg::MAX_COUNT_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/bbs_checker.sv
// port-level checker for the byte block sorter, bound to the top level
// depends on bbs_pkg and byte_block_sorter_top
`default_nettype none

module bbs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic [7:0]                  in_tdata,
  input wire logic                        in_tlast,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [bbs_pkg::VALUE_W-1:0] out_tdata,
  input wire logic                        out_tlast,
  input wire logic                        out_tuser
);

  logic                        mid_r;   // inside a block's output
  logic [bbs_pkg::VALUE_W-1:0] prev_r;  // last delivered byte
  logic                        out_acc;

  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (out_acc) begin
      mid_r <= !out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_r <= out_tdata;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // no new requests are taken while a block is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during output");

  // results of one block come out in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && mid_r |-> out_tdata >= prev_r)
    else $error("results not ascending");

  // overflow flag is the same on every result of a block
  a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && mid_r |-> out_tuser == $past(out_tuser))
    else $error("overflow flag changed within block");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  logic unused_in;
  assign unused_in = ^{in_tdata, in_tlast, in_tvalid};

endmodule

bind byte_block_sorter_top bbs_checker u_bbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### bench/byte_block_sorter_top_tb.sv
// self-checking bench for byte_block_sorter_top: random byte blocks in, sorted bytes out
// depends on bbs_pkg and the byte_block_sorter_top rtl; a scoreboard class predicts each block
`timescale 1ns / 1ps

module byte_block_sorter_top_tb;

  localparam int CAP          = bbs_pkg::MAX_COUNT_DEF;
  localparam int ITEM_TARGET  = 280;     // rough size of the random part
  localparam int HOLD_CYCLES  = 300;     // long sink hold-off to back up the input
  localparam int DRAIN_CYCLES = 40;      // quiet time after the last expected result
  localparam int LIMIT_CYCLES = 200000;  // run watchdog

  // backpressure profiles, stepped through during the random part
  typedef enum int {
    PH_STEADY,       // no idling at all
    PH_SLOW_SOURCE,  // sender gap chance 66 percent
    PH_SLOW_SINK,    // receiver stall chance 66 percent
    PH_LIGHT         // sender gap and receiver stall chance 8 percent each
  } idle_phase_e;

  // one predicted result request
  typedef struct packed {
    logic [7:0] value;
    logic       final_mark;
    logic       dropped;
  } sorted_byte_t;

  // tracks the block being loaded and the sorted bytes still owed by the dut
  class byte_sort_scoreboard;
    logic [7:0]   open_block[$];
    bit           overflow_hit;
    sorted_byte_t sorted_due[$];
    int           failures;

    function void note_byte(logic [7:0] value, logic closes);
      logic [7:0]   ordered[$];
      logic [7:0]   key;
      int           j;
      sorted_byte_t entry;
      if (open_block.size() < CAP) begin
        open_block.push_back(value);
      end else begin
        overflow_hit = 1'b1;
      end
      if (!closes) return;
      // stable insertion sort: equal bytes keep arrival order
      ordered = open_block;
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      foreach (ordered[i]) begin
        entry.value      = ordered[i];
        entry.final_mark = (i == ordered.size() - 1);
        entry.dropped    = overflow_hit;
        sorted_due.push_back(entry);
      end
      open_block.delete();
      overflow_hit = 1'b0;
    endfunction

    function void check_byte(logic [7:0] value, logic final_mark, logic dropped);
      sorted_byte_t want;
      if (sorted_due.size() == 0) begin
        $error("unexpected result: sorted_value %0d final_value %0b overflowed %0b",
               value, final_mark, dropped);
        failures++;
        return;
      end
      want = sorted_due.pop_front();
      if (value !== want.value) begin
        $error("sorted_value: expected %0d, got %0d", want.value, value);
        failures++;
      end
      if (final_mark !== want.final_mark) begin
        $error("final_value: expected %0b, got %0b", want.final_mark, final_mark);
        failures++;
      end
      if (dropped !== want.dropped) begin
        $error("overflowed: expected %0b, got %0b", want.dropped, dropped);
        failures++;
      end
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  byte_sort_scoreboard sb = new;

  int idle_pct  = 0;     // sender gap chance, percent
  int stall_pct = 0;     // receiver stall chance, percent
  bit hold_ask  = 1'b0;  // sender asks the receiver for one long hold-off

  byte_block_sorter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // watchdog: a hung handshake or a lost result ends here
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("byte_block_sorter_top_tb: FAIL");
    $finish;
  end

  // result side: check on accepted requests, then pick the next tready
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_byte(out_tdata, out_tlast, out_tuser);
      end
      // long hold-off counted here, the sender keeps offering meanwhile
      if (hold_ask && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one byte, with an optional gap first; returns after the handshake
  task automatic send_byte(input logic [7:0] value, input logic closes);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= closes;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(value, closes);
  endtask

  // whole block, tlast on its final byte
  task automatic send_block(input logic [7:0] block_bytes[$]);
    foreach (block_bytes[i]) begin
      send_byte(block_bytes[i], i == block_bytes.size() - 1);
    end
  endtask

  // extremes and repeats show up more often than plain random would give
  function automatic logic [7:0] pick_byte(input logic [7:0] last_pick);
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    if (r < 35) return last_pick;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [7:0]  blk[$];
    logic [7:0]  prev;
    int          len;
    int          sent;
    int          blocks;
    int          r;
    idle_phase_e phase;

    sent   = 0;
    blocks = 0;
    prev   = 8'h00;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single-byte blocks at both extremes
    blk = {8'h00};
    send_block(blk);
    blk = {8'hFF};
    send_block(blk);
    // mixed block with a repeated byte
    blk = {8'h80, 8'h7F, 8'hFF, 8'h00, 8'h55, 8'h55};
    send_block(blk);
    // full block in descending order, then a closing byte that gets dropped
    blk.delete();
    for (int k = 0; k < CAP; k++) blk.push_back(8'(255 - k));
    blk.push_back(8'h00);
    send_block(blk);

    // random blocks, stepping the backpressure profile every few blocks
    while (sent < ITEM_TARGET) begin
      phase = idle_phase_e'((blocks / 3) % 4);
      case (phase)
        PH_STEADY: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        PH_SLOW_SOURCE: begin
          idle_pct  = 66;
          stall_pct = 0;
        end
        PH_SLOW_SINK: begin
          idle_pct  = 0;
          stall_pct = 66;
        end
        default: begin
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      if (blocks == 1) hold_ask = 1'b1;

      // mostly in-range blocks, some exactly full, some overflowing
      r = $urandom_range(99);
      if (r < 10)      len = 1;
      else if (r < 78) len = $urandom_range(CAP, 2);
      else if (r < 88) len = CAP;
      else             len = $urandom_range(CAP + 4, CAP + 1);

      blk.delete();
      for (int k = 0; k < len; k++) begin
        prev = pick_byte(prev);
        blk.push_back(prev);
      end
      send_block(blk);
      sent += len;
      blocks++;
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // let the last block drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("byte_block_sorter_top_tb: PASS");
    end else begin
      $display("byte_block_sorter_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/bbs_pkg.sv
rtl/bbs_ram.sv
rtl/byte_block_sorter_top.sv
rtl/bbs_checker.sv
bench/byte_block_sorter_top_tb.sv
